// ===== sv/fsl_pkg.sv =====
package fsl_pkg;

  // Fixed field widths of the request and configuration items.
  localparam int TAP_IDX_W = 7;
  localparam int TAP_CNT_W = 8;

  // Reset value of the tap count register.
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 8'd1;

  // Request kinds carried in the input tuser.
  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic acc_clr;   // start a new output sum
    logic issue;     // a tap and a sample are being read this cycle
    logic zero_smp;  // the sample read lies before the signal start
  } mac_ctrl_t;

endpackage

// ===== sv/fsl_ram.sv =====
module fsl_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 16,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/fsl_mac.sv =====
module fsl_mac #(
  parameter int MAX_TAPS     = 128,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fsl_pkg::mac_ctrl_t      ctrl,
  input  logic [COEF_WIDTH-1:0]   tap_rd,
  input  logic [SAMPLE_WIDTH-1:0] smp_rd,
  output logic                    busy,
  output logic [SAMPLE_WIDTH-1:0] result
);
  import fsl_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS + 1);
  localparam int FRAC   = COEF_WIDTH - 1;

  localparam logic signed [ACC_W:0] RND =
    {{(ACC_W - COEF_WIDTH + 2){1'b0}}, 1'b1, {(COEF_WIDTH - 2){1'b0}}};
  localparam logic signed [ACC_W:0] SAT_HI =
    {{(ACC_W - SAMPLE_WIDTH + 2){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_LO =
    {{(ACC_W - SAMPLE_WIDTH + 2){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

  logic                     v1_r;
  logic                     v2_r;
  logic                     zero1_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [SAMPLE_WIDTH-1:0]  smp_op;
  logic signed [ACC_W:0]    rnd_sum;
  logic signed [ACC_W:0]    rnd_shr;

  // Samples before the start of the signal count as zero.
  assign smp_op = zero1_r ? '0 : smp_rd;

  // Stage valids follow the memory read and the product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      zero1_r <= 1'b0;
    end else begin
      v1_r    <= ctrl.issue;
      v2_r    <= v1_r;
      zero1_r <= ctrl.zero_smp;
    end
  end

  // Product register, then the accumulator.
  always_ff @(posedge clk) begin
    prod_r <= $signed(tap_rd) * $signed(smp_op);
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  assign busy = v1_r | v2_r;

  // Round half up, drop the fraction, then saturate to the sample range.
  always_comb begin
    rnd_sum = (ACC_W + 1)'(acc_r) + RND;
    rnd_shr = rnd_sum >>> FRAC;
    if (rnd_shr > SAT_HI) begin
      result = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (rnd_shr < SAT_LO) begin
      result = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      result = rnd_shr[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// ===== sv/fir_filter_same_length_unit.sv =====
// Coefficient items and sample items that yield no result are taken in idle.
// Each result takes one tap read per cycle from the tap and history memories
// into a single multiply-accumulate, then a pipeline drain, then a hand-over
// of the result once the output register is free; no new item is taken until
// the block is back in idle.
// A last sample yields up to (K-1)/2 + 1 results in turn.
// Synchronous active-low reset clears control state and sets K to 1; the
// tap memory holds no reset value, the history needs no clearing pass.
module fir_filter_same_length_unit #(
  parameter int MAX_TAPS     = 128,
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 16
) (
  input  logic clk,
  input  logic rst_n,
  // Input items.
  input  logic in_tvalid,
  output logic in_tready,
  // tdata from bit 0: tap_index, coefficient, sample_in, zero padding.
  input  logic [((fsl_pkg::TAP_IDX_W + COEF_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  // tuser: req_type.
  input  logic in_tuser,
  input  logic in_tlast,
  // Result items.
  output logic out_tvalid,
  input  logic out_tready,
  // tdata from bit 0: filtered_sample, zero padding.
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  output logic out_tlast,
  // Tap count register.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fsl_pkg::TAP_CNT_W-1:0]  cfg_data
);
  import fsl_pkg::*;

  localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int CMP_W  = (CNT_W > TAP_CNT_W) ? CNT_W : TAP_CNT_W;
  localparam int OUT_DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TAPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [TAP_CNT_W-1:0]    tap_count_r, tap_count_nxt;
  logic [IDX_W-1:0]        ptr_r, ptr_nxt;
  logic [IDX_W-1:0]        seen_r, seen_nxt;
  logic [IDX_W-1:0]        newest_r, newest_nxt;
  logic [IDX_W-1:0]        seen_item_r, seen_item_nxt;
  logic [IDX_W-1:0]        kend_r, kend_nxt;
  logic [IDX_W-1:0]        offset_r, offset_nxt;
  logic [IDX_W-1:0]        lead_r, lead_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [IDX_W-1:0]        back_r, back_nxt;
  logic [IDX_W-1:0]        haddr_r, haddr_nxt;
  logic                    last_item_r, last_item_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [TAP_IDX_W-1:0]    f_tap_index;
  logic [COEF_WIDTH-1:0]   f_coef;
  logic [SAMPLE_WIDTH-1:0] f_sample;
  logic                    in_acc;
  logic                    is_sample;
  logic                    idx_ok;
  logic                    coef_wr;
  logic                    hist_wr;
  logic [CMP_W-1:0]        tc_ext;
  logic [CNT_W-1:0]        k_cnt;
  logic [IDX_W-1:0]        kend_now;
  logic [IDX_W-1:0]        offset_now;
  logic [IDX_W-1:0]        first_lead;
  logic                    out_free;
  logic                    acc_clr;
  mac_ctrl_t               mac_ctrl;
  logic [COEF_WIDTH-1:0]   tap_rd;
  logic [SAMPLE_WIDTH-1:0] smp_rd;
  logic                    mac_busy;
  logic [SAMPLE_WIDTH-1:0] mac_result;

  // Unpack the input item.
  assign f_tap_index = in_tdata[TAP_IDX_W-1:0];
  assign f_coef      = in_tdata[TAP_IDX_W +: COEF_WIDTH];
  assign f_sample    = in_tdata[TAP_IDX_W + COEF_WIDTH +: SAMPLE_WIDTH];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign is_sample = (in_tuser == REQ_SAMPLE);
  assign idx_ok    = (32'(f_tap_index) < 32'(MAX_TAPS));
  assign coef_wr   = in_acc && (in_tuser == REQ_COEF) && idx_ok;
  assign hist_wr   = in_acc && is_sample;
  assign cfg_ready = 1'b1;

  // Taps in use: zero acts as one, anything above the table size as the size.
  always_comb begin
    tc_ext = CMP_W'(tap_count_r);
    if (tc_ext == '0) begin
      k_cnt = CNT_W'(1);
    end else if (tc_ext > CMP_W'(MAX_TAPS)) begin
      k_cnt = CNT_W'(MAX_TAPS);
    end else begin
      k_cnt = CNT_W'(tc_ext);
    end
    kend_now   = IDX_W'(k_cnt - CNT_W'(1));
    offset_now = IDX_W'((k_cnt - CNT_W'(1)) >> 1);
    first_lead = (seen_r >= offset_now) ? '0 : IDX_W'(offset_now - seen_r);
  end

  assign out_free = !out_valid_r || out_tready;

  // Sequencer: one tap read per cycle, then drain, then hand the result over.
  always_comb begin
    state_nxt     = state_r;
    tap_count_nxt = tap_count_r;
    ptr_nxt       = ptr_r;
    seen_nxt      = seen_r;
    newest_nxt    = newest_r;
    seen_item_nxt = seen_item_r;
    kend_nxt      = kend_r;
    offset_nxt    = offset_r;
    lead_nxt      = lead_r;
    k_nxt         = k_r;
    back_nxt      = back_r;
    haddr_nxt     = haddr_r;
    last_item_nxt = last_item_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    acc_clr       = 1'b0;

    if (cfg_valid && cfg_ready) begin
      tap_count_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && is_sample) begin
          newest_nxt    = ptr_r;
          seen_item_nxt = seen_r;
          kend_nxt      = kend_now;
          offset_nxt    = offset_now;
          back_nxt      = '0;
          haddr_nxt     = ptr_r;
          last_item_nxt = in_tlast;
          if (in_tlast) begin
            // The last sample flushes every outstanding output.
            ptr_nxt   = '0;
            seen_nxt  = '0;
            lead_nxt  = first_lead;
            k_nxt     = first_lead;
            acc_clr   = 1'b1;
            state_nxt = S_RUN;
          end else begin
            ptr_nxt  = (ptr_r == LAST_IDX) ? '0 : ptr_r + IDX_W'(1);
            seen_nxt = (seen_r == LAST_IDX) ? seen_r : seen_r + IDX_W'(1);
            if (seen_r >= offset_now) begin
              lead_nxt  = '0;
              k_nxt     = '0;
              acc_clr   = 1'b1;
              state_nxt = S_RUN;
            end
          end
        end
      end
      S_RUN: begin
        k_nxt     = k_r + IDX_W'(1);
        back_nxt  = back_r + IDX_W'(1);
        haddr_nxt = (haddr_r == '0) ? LAST_IDX : haddr_r - IDX_W'(1);
        if (k_r == kend_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mac_result;
          out_last_nxt  = last_item_r && (lead_r == offset_r);
          if (last_item_r && (lead_r != offset_r)) begin
            lead_nxt  = lead_r + IDX_W'(1);
            k_nxt     = lead_r + IDX_W'(1);
            back_nxt  = '0;
            haddr_nxt = newest_r;
            acc_clr   = 1'b1;
            state_nxt = S_RUN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_count_r <= TAP_COUNT_RST;
      ptr_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_count_r <= tap_count_nxt;
      ptr_r       <= ptr_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    newest_r    <= newest_nxt;
    seen_item_r <= seen_item_nxt;
    kend_r      <= kend_nxt;
    offset_r    <= offset_nxt;
    lead_r      <= lead_nxt;
    k_r         <= k_nxt;
    back_r      <= back_nxt;
    haddr_r     <= haddr_nxt;
    last_item_r <= last_item_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Control to the multiply-accumulate unit.
  always_comb begin
    mac_ctrl.acc_clr  = acc_clr;
    mac_ctrl.issue    = (state_r == S_RUN);
    mac_ctrl.zero_smp = (back_r > seen_item_r);
  end

  // Tap table.
  fsl_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (COEF_WIDTH),
    .AW    (IDX_W)
  ) u_tap_ram (
    .clk     (clk),
    .wr_en   (coef_wr),
    .wr_addr (IDX_W'(f_tap_index)),
    .wr_data (f_coef),
    .rd_addr (k_r),
    .rd_data (tap_rd)
  );

  // Sample history, a ring indexed by the write pointer.
  fsl_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (SAMPLE_WIDTH),
    .AW    (IDX_W)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_wr),
    .wr_addr (ptr_r),
    .wr_data (f_sample),
    .rd_addr (haddr_r),
    .rd_data (smp_rd)
  );

  fsl_mac #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .tap_rd (tap_rd),
    .smp_rd (smp_rd),
    .busy   (mac_busy),
    .result (mac_result)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_data_r);
  assign out_tlast  = out_last_r;

  // A last sample leaves an empty history for the next signal.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_sample && in_tlast) |=> (ptr_r == '0 && seen_r == '0))
    else $error("history pointer or count not cleared after last sample");

  // A result is only taken from a fully drained accumulator.
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !mac_busy)
    else $error("result taken while products still in flight");

  // The tap walk never passes the last tap in use.
  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (k_r <= kend_r && lead_r <= offset_r))
    else $error("tap index beyond the taps in use");

  // No new item is taken while products are still in flight.
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    mac_busy |-> !in_tready)
    else $error("input accepted while the accumulator is busy");

endmodule

// ===== verif/tb_fir_filter_same_length_unit.sv =====
`timescale 1ns / 1ps

// Tracks the filter state on the testbench side and holds the outputs still owed by the block.
class fir_tracker;

  typedef struct {
    logic [15:0] value;
    logic        is_last;
  } fir_out_t;

  logic signed [15:0] tap_mem [128];
  logic signed [15:0] history [128];
  logic [6:0]         wr_ptr;
  int unsigned        seen_cnt;
  logic [7:0]         tap_reg;
  fir_out_t           owed_outputs [$];
  int                 errors;

  function new();
    wr_ptr   = '0;
    seen_cnt = 0;
    tap_reg  = fsl_pkg::TAP_COUNT_RST;
    errors   = 0;
    foreach (tap_mem[i]) tap_mem[i] = '0;
    foreach (history[i]) history[i] = '0;
  endfunction

  function void set_tap_count(logic [7:0] value);
    tap_reg = value;
  endfunction

  // One point of the full convolution, 'lead' places past the newest sample.
  // Samples after the newest one count as zero.
  function logic [15:0] conv_output_at(int unsigned lead, int unsigned taps);
    logic [6:0]  newest;
    logic [6:0]  pos;
    longint      acc;
    longint      rounded;
    int unsigned k;
    newest = wr_ptr - 7'd1;
    acc    = 0;
    for (k = lead; k < taps; k++) begin
      pos = newest - 7'(k - lead);
      acc += longint'(tap_mem[k]) * longint'(history[pos]);
    end
    // Round half up, then floor to Q1.15 and saturate.
    rounded = (acc + 64'sd16384) >>> 15;
    if (rounded > 64'sd32767) begin
      rounded = 64'sd32767;
    end else if (rounded < -64'sd32768) begin
      rounded = -64'sd32768;
    end
    return rounded[15:0];
  endfunction

  // Called for every accepted input item.
  function void note_input(logic req, logic [6:0] idx, logic [15:0] coef,
                           logic [15:0] smp, logic is_last);
    int unsigned taps;
    int unsigned offset;
    int unsigned prior;
    int unsigned first;
    int unsigned lead;
    fir_out_t    owed;
    if (req == fsl_pkg::REQ_COEF) begin
      tap_mem[idx] = coef;
      return;
    end
    // A zero count behaves as one tap, anything above the table size as the full table.
    taps   = (tap_reg == 8'd0) ? 1 : ((tap_reg > 8'd128) ? 128 : int'(tap_reg));
    offset = (taps - 1) / 2;
    prior  = seen_cnt;
    history[wr_ptr] = smp;
    wr_ptr++;
    if (!is_last) begin
      if (prior >= offset) begin
        owed.value   = conv_output_at(0, taps);
        owed.is_last = 1'b0;
        owed_outputs.insert(owed_outputs.size(), owed);
      end
      if (seen_cnt < 127) seen_cnt++;
      return;
    end
    // The last sample flushes every outstanding output against zero padding.
    first = (prior >= offset) ? 0 : offset - prior;
    for (lead = first; lead <= offset; lead++) begin
      owed.value   = conv_output_at(lead, taps);
      owed.is_last = (lead == offset);
      owed_outputs.insert(owed_outputs.size(), owed);
    end
    foreach (history[i]) history[i] = '0;
    wr_ptr   = '0;
    seen_cnt = 0;
  endfunction

  // Called for every accepted result item.
  function void check_result(logic [15:0] value, logic is_last);
    fir_out_t owed;
    if (owed_outputs.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual sample %h last %b",
               $time, value, is_last);
      return;
    end
    owed = owed_outputs.pop_front();
    if (value !== owed.value) begin
      errors++;
      $display("%0t: filtered_sample mismatch, expected %h actual %h",
               $time, owed.value, value);
    end
    if (is_last !== owed.is_last) begin
      errors++;
      $display("%0t: last_result mismatch, expected %b actual %b",
               $time, owed.is_last, is_last);
    end
  endfunction

endclass

module tb_fir_filter_same_length_unit;
  import fsl_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // tdata from bit 0: tap_index, coefficient, sample_in, zero padding.
  logic [39:0] in_tdata   = '0;
  // tuser: req_type.
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // tdata from bit 0: filtered_sample.
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  fir_tracker fir_chk = new();

  int burst_left = 0;
  int items_sent = 0;
  int rx_mode    = 0;
  int rx_left    = 0;

  fir_filter_same_length_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // The receiver switches at random between stall patterns.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= (rx_left % 4 == 0);
      end
      default: begin
        out_tready <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  // Every accepted result item is checked against the oldest owed output.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      fir_chk.check_result(out_tdata, out_tlast);
    end
  end

  // Mostly random values, with the extremes and zero turning up often.
  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drives one input item in bursts with random gaps; starts and ends at a falling edge.
  task automatic send_item(logic req, logic [6:0] idx, logic [15:0] coef,
                           logic [15:0] smp, logic is_last);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 6))
        @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tlast  <= is_last;
    in_tdata  <= {1'b0, smp, coef, idx};
    do @(posedge clk); while (!in_tready);
    fir_chk.note_input(req, idx, coef, smp, is_last);
    items_sent++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_sample(logic [15:0] smp, logic is_last);
    send_item(REQ_SAMPLE, 7'($urandom), 16'($urandom), smp, is_last);
  endtask

  task automatic send_coef(logic [6:0] idx, logic [15:0] coef);
    send_item(REQ_COEF, idx, coef, 16'($urandom), 1'($urandom));
  endtask

  // Holds the sender until every owed output has come and the block has settled.
  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (fir_chk.owed_outputs.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_tap_count(logic [7:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    fir_chk.set_tap_count(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    int   goal;
    int   len;
    int   pick;
    logic open_signal;
    logic [7:0] taps;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill the whole tap table so that no unwritten tap is ever read.
    for (int i = 0; i < 128; i++) begin
      send_coef(7'(i), ($urandom_range(0, 3) == 0) ? pick_value()
                                                   : 16'($signed($urandom_range(0, 8191)) - 4096));
    end

    // Positive saturation with three most-negative taps and samples.
    write_tap_count(8'd3);
    send_coef(7'd0, 16'h8000);
    send_coef(7'd1, 16'h8000);
    send_coef(7'd2, 16'h8000);
    send_coef(7'd127, 16'h7fff);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b1);
    // Negative saturation.
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h7fff, 1'b1);
    // A zero tap count behaves as a single tap.
    write_tap_count(8'd0);
    send_sample(16'h7fff, 1'b1);
    // A count above the table size behaves as the full table; short signal flush.
    write_tap_count(8'd255);
    send_sample(16'h1234, 1'b0);
    send_sample(16'h8000, 1'b1);
    // Short signal shorter than the trim offset.
    write_tap_count(8'd9);
    send_sample(pick_value(), 1'b0);
    send_sample(pick_value(), 1'b1);
    // Full table, one-sample signal.
    write_tap_count(8'd128);
    send_sample(16'h7fff, 1'b1);

    // Random signals under a range of tap counts, mostly short ones.
    goal        = items_sent + 100;
    open_signal = 1'b0;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        taps = 8'($urandom_range(1, 12));
      end else if (pick == 7) begin
        taps = 8'($urandom_range(13, 40));
      end else if (pick == 8) begin
        taps = 8'($urandom_range(41, 128));
      end else begin
        taps = ($urandom_range(0, 1) == 0) ? 8'd128 : 8'($urandom_range(0, 255));
      end
      // Changing the count between phases also covers a change in mid-signal.
      write_tap_count(taps);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
      open_signal = ($urandom_range(0, 5) == 0);
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 7) == 0) begin
          send_coef(7'($urandom), pick_value());
        end
        send_sample(pick_value(), (j == len - 1) && !open_signal);
      end
    end
    if (open_signal) begin
      send_sample(pick_value(), 1'b1);
    end

    // Let any stray result show up before judging.
    wait_drained();
    repeat (200) @(negedge clk);
    if (fir_chk.errors == 0 && fir_chk.owed_outputs.size() == 0) begin
      $display("fir_filter_same_length_unit regression: pass");
    end else begin
      $display("fir_filter_same_length_unit regression: fail");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #60000000;
    $display("fir_filter_same_length_unit regression: fail");
    $finish;
  end

endmodule

// ===== fir_filter_same_length_unit.f =====
sv/fsl_pkg.sv
sv/fsl_ram.sv
sv/fsl_mac.sv
sv/fir_filter_same_length_unit.sv
verif/tb_fir_filter_same_length_unit.sv
